>>> rtl/core/lht_pkg.sv
package lht_pkg;

  localparam int unsigned TABLE_ENTRIES = 8;
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned HOP_W         = 7;
  localparam int unsigned USED_W        = 4;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [HOP_W-1:0] HOP_MAX = {HOP_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_IS_LANDMARK    = 2'd0,
    CFG_CORRECTION_RECEIVED = 2'd1,
    CFG_POSITIONING_DONE    = 2'd2
  } cfg_idx_e;

  // One advertisement walking down the chain of table cells.
  typedef struct packed {
    logic               live;
    logic               done;
    logic               relay;
    logic               appended;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [HOP_W-1:0]   total;
  } probe_t;

endpackage

>>> rtl/core/lht_if.sv
interface lht_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_coord;
  logic [31:0] y_coord;
  logic [6:0]  hop_count;

  modport source(output valid, output x_coord, output y_coord, output hop_count,
                 input ready);
  modport sink(input valid, input x_coord, input y_coord, input hop_count,
               output ready);
endinterface

interface lht_out_if;
  logic        valid;
  logic        ready;
  logic        relay;
  logic [31:0] relay_x;
  logic [31:0] relay_y;
  logic [6:0]  relay_hops;
  logic [3:0]  entries_used;
  logic        start_positioning;
  logic        start_correction;

  modport source(output valid, output relay, output relay_x, output relay_y,
                 output relay_hops, output entries_used, output start_positioning,
                 output start_correction, input ready);
  modport sink(input valid, input relay, input relay_x, input relay_y,
               input relay_hops, input entries_used, input start_positioning,
               input start_correction, output ready);
endinterface

>>> rtl/core/lht_cell.sv
module lht_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lht_pkg::probe_t probe_i,
  output lht_pkg::probe_t probe_o
);
  import lht_pkg::*;

  logic               valid_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [HOP_W-1:0]   hops_q;
  logic               live_q;
  probe_t             pay_q;
  probe_t             pay_d;
  logic               searching;
  logic               hit;
  logic               fill;
  logic               better;

  assign searching = probe_i.live && !probe_i.done;
  assign hit       = searching && valid_q && (x_q == probe_i.x) && (y_q == probe_i.y);
  // Entries fill in order, so the first empty cell marks the end of the search.
  assign fill      = searching && !valid_q;
  assign better    = probe_i.total <= hops_q;

  always_comb begin
    pay_d = probe_i;
    if (hit) begin
      pay_d.done  = 1'b1;
      pay_d.relay = better;
    end else if (fill) begin
      pay_d.done     = 1'b1;
      pay_d.appended = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      live_q  <= 1'b0;
    end else begin
      live_q <= probe_i.live;
      if (fill) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    if (fill || (hit && better)) begin
      hops_q <= probe_i.total;
    end
    if (fill) begin
      x_q <= probe_i.x;
      y_q <= probe_i.y;
    end
  end

  always_comb begin
    probe_o      = pay_q;
    probe_o.live = live_q;
  end

  a_valid_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> valid_q) else $error("table entry lost its valid bit");

  a_live_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q |-> $past(probe_i.live)) else $error("probe appeared without a source");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill |=> (valid_q && probe_o.appended)) else $error("append did not take");

endmodule

>>> rtl/core/landmark_hop_table.sv
// Channel | Dir | Transfer when   | Payload
// adv_i   | in  | valid && ready  | x_coord, y_coord, hop_count
// res_o   | out | valid && ready  | relay, relay_x/y/hops, entries_used, start flags
// cfg     | in  | cfg_we_i        | cfg_idx_i selects register, cfg_data_i bit 0
//
// An advertisement walks the row of TABLE_ENTRIES cells, one cell per cycle, and
// its result is then registered and held on res_o.
// One advertisement at a time: the next is taken once the result has transferred.
// rst_ni clears the valid bits, the fill count and the configuration at once.
// A stalled result holds on res_o; adv_i stays not ready meanwhile.
module landmark_hop_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lht_in_if.sink                           adv_i,
  lht_out_if.source                        res_o,
  input  logic                             cfg_we_i,
  input  logic [lht_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [0:0]                       cfg_data_i
);
  import lht_pkg::*;

  probe_t             chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] live_vec;
  logic               busy_q;
  logic               out_valid_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;
  logic               is_landmark_q;
  logic               corr_rcvd_q;
  logic               pos_done_q;
  logic               in_xfer;
  logic               out_xfer;
  logic               done_probe;
  logic               full_d;

  logic               relay_q;
  logic [COORD_W-1:0] relay_x_q;
  logic [COORD_W-1:0] relay_y_q;
  logic [HOP_W-1:0]   relay_hops_q;
  logic [USED_W-1:0]  used_q;
  logic               start_pos_q;
  logic               start_corr_q;

  assign adv_i.ready = !busy_q;
  assign in_xfer     = adv_i.valid && !busy_q;
  assign out_xfer    = out_valid_q && res_o.ready;

  always_comb begin
    chain[0].live     = in_xfer;
    // A hop count at the maximum cannot be incremented: skip the search.
    chain[0].done     = (adv_i.hop_count == HOP_MAX);
    chain[0].relay    = 1'b0;
    chain[0].appended = 1'b0;
    chain[0].x        = adv_i.x_coord;
    chain[0].y        = adv_i.y_coord;
    chain[0].total    = adv_i.hop_count + HOP_W'(1);
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    lht_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
    assign live_vec[k] = chain[k+1].live;
  end

  assign done_probe = chain[TABLE_ENTRIES].live;
  assign count_d    = count_q + CNT_W'(chain[TABLE_ENTRIES].appended);
  assign full_d     = (count_d == CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      count_q       <= '0;
      is_landmark_q <= 1'b0;
      corr_rcvd_q   <= 1'b0;
      pos_done_q    <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q <= 1'b1;
      end else if (out_xfer) begin
        busy_q <= 1'b0;
      end
      if (done_probe) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NODE_IS_LANDMARK:    is_landmark_q <= cfg_data_i[0];
          CFG_CORRECTION_RECEIVED: corr_rcvd_q   <= cfg_data_i[0];
          CFG_POSITIONING_DONE:    pos_done_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_probe) begin
      relay_q      <= chain[TABLE_ENTRIES].relay;
      relay_x_q    <= chain[TABLE_ENTRIES].relay ? chain[TABLE_ENTRIES].x : '0;
      relay_y_q    <= chain[TABLE_ENTRIES].relay ? chain[TABLE_ENTRIES].y : '0;
      relay_hops_q <= chain[TABLE_ENTRIES].relay ? chain[TABLE_ENTRIES].total : '0;
      used_q       <= USED_W'(count_d);
      start_pos_q  <= full_d && !is_landmark_q && corr_rcvd_q && !pos_done_q;
      start_corr_q <= full_d && is_landmark_q && !corr_rcvd_q;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.relay             = relay_q;
  assign res_o.relay_x           = relay_x_q;
  assign res_o.relay_y           = relay_y_q;
  assign res_o.relay_hops        = relay_hops_q;
  assign res_o.entries_used      = used_q;
  assign res_o.start_positioning = start_pos_q;
  assign res_o.start_correction  = start_corr_q;

  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({live_vec, out_valid_q})) else $error("more than one item in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES)) else $error("fill count past table size");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q || (|live_vec)) |-> busy_q) else $error("result while idle");

endmodule
